// ===== rtl/core/tsct_pkg.sv =====
// shared constants for the taylor sine, cosine and tangent pipeline
package tsct_pkg;

  localparam int TERMS_DEF     = 16;
  localparam int FRAC_BITS_DEF = 28;

  localparam int ACT_W = 2;
  localparam int IN_W  = 31;
  localparam int OUT_W = 36;

  localparam logic [ACT_W-1:0] ACT_SIN = 2'd0;
  localparam logic [ACT_W-1:0] ACT_COS = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TAN = 2'd2;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== rtl/core/taylor_sine_cosine_tangent.sv =====
// top level: pipelined taylor series sine, cosine and tangent
//
//   channel  ports                                   transfer when
//   input    start, busy, in_action, in_angle        start & !busy
//   result   out_valid, out_value, out_overflow      out_valid (one cycle)
//
// one item enters every cycle; busy stays low, the pipeline never stalls
// the path runs through the front end (clamp register, x squared multiplier,
// first-term register), per series term two split multipliers and an add,
// setup registers for sign fix-up and divider load, one quotient bit per stage
// over 36 stages, and the output register
// sine and cosine are summed side by side in every item; the restoring
// divider sets the depth of the tangent tail
// synchronous active-low reset clears only the valid bits
module taylor_sine_cosine_tangent #(
  parameter int TERMS     = tsct_pkg::TERMS_DEF,
  parameter int FRAC_BITS = tsct_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [tsct_pkg::ACT_W-1:0]    in_action,
  input  logic signed [tsct_pkg::IN_W-1:0]     in_angle,
  output logic                                 out_valid,
  output logic signed [tsct_pkg::OUT_W-1:0]    out_value,
  output logic                                 out_overflow
);
  import tsct_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int MW  = F + 2;            // clamped angle magnitude
  localparam int XW  = F + 4;            // x squared
  localparam int TW  = F + 4;            // series term magnitude
  localparam int PW  = F + 8;            // term times x squared
  localparam int RCW = F;                // reciprocal constants
  localparam int SW  = F + 6;            // signed partial sums
  localparam int AWD = (IN_W > MW) ? IN_W : MW;
  localparam int EW  = ((SW > OUT_W) ? SW : OUT_W) + 1;
  localparam int VW  = SW + F + 37;      // divider remainder width
  localparam int QB  = OUT_W;            // quotient bits

  localparam logic [AWD-1:0]        MAXMAG = AWD'((64'd4 << F) - 64'd1);
  localparam logic [TW-1:0]         ONE_T  = TW'(1) << F;
  localparam logic signed [EW-1:0]  MAX_E  = EW'(OUT_MAX);
  localparam logic signed [EW-1:0]  MIN_E  = EW'(OUT_MIN);

  // the pipeline takes an item every cycle
  assign busy = 1'b0;

  // ---------------- front end: magnitude and clamp ----------------
  logic [IN_W-1:0] abs_in;
  logic [AWD-1:0]  abs_w;
  logic [MW-1:0]   mag_nxt;

  assign abs_in  = in_angle[IN_W-1] ? IN_W'(-in_angle) : IN_W'(in_angle);
  assign abs_w   = AWD'(abs_in);
  assign mag_nxt = MW'((abs_w > MAXMAG) ? MAXMAG : abs_w);

  logic [MW-1:0]    a_mag_r;
  logic             a_neg_r;
  logic [ACT_W-1:0] a_act_r;
  logic             a_v_r;

  always_ff @(posedge clk) begin
    a_mag_r <= mag_nxt;
    a_neg_r <= in_angle[IN_W-1];
    a_act_r <= in_action;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= start & ~busy;
    end
  end

  // x squared; side data rides along
  logic [XW-1:0]    x2;
  logic [MW-1:0]    b_mag_r [0:1];
  logic             b_neg_r [0:1];
  logic [ACT_W-1:0] b_act_r [0:1];
  logic             b_v_r   [0:1];

  tsct_mul #(.AW(MW), .BW(MW), .SH(F), .OW(XW)) u_x2 (
    .clk (clk),
    .a   (a_mag_r),
    .b   (a_mag_r),
    .p   (x2)
  );

  always_ff @(posedge clk) begin
    b_mag_r[0] <= a_mag_r;
    b_neg_r[0] <= a_neg_r;
    b_act_r[0] <= a_act_r;
    b_mag_r[1] <= b_mag_r[0];
    b_neg_r[1] <= b_neg_r[0];
    b_act_r[1] <= b_act_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r[0] <= 1'b0;
      b_v_r[1] <= 1'b0;
    end else begin
      b_v_r[0] <= a_v_r;
      b_v_r[1] <= b_v_r[0];
    end
  end

  // ---------------- series chain ----------------
  logic [XW-1:0]        ch_x2  [0:TERMS-1];
  logic [TW-1:0]        ch_ts  [0:TERMS-1];
  logic [TW-1:0]        ch_tc  [0:TERMS-1];
  logic signed [SW-1:0] ch_ss  [0:TERMS-1];
  logic signed [SW-1:0] ch_sc  [0:TERMS-1];
  logic                 ch_neg [0:TERMS-1];
  logic [ACT_W-1:0]     ch_act [0:TERMS-1];
  logic                 ch_v   [0:TERMS-1];

  // first term: x for sine, one for cosine
  always_ff @(posedge clk) begin
    ch_x2[0]  <= x2;
    ch_ts[0]  <= TW'(b_mag_r[1]);
    ch_tc[0]  <= ONE_T;
    ch_ss[0]  <= SW'(b_mag_r[1]);
    ch_sc[0]  <= SW'(ONE_T);
    ch_neg[0] <= b_neg_r[1];
    ch_act[0] <= b_act_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_v[0] <= 1'b0;
    end else begin
      ch_v[0] <= b_v_r[1];
    end
  end

  for (genvar k = 1; k < TERMS; k++) begin : g_term
    localparam longint unsigned DS  = 64'((2 * k + 1) * (2 * k));
    localparam longint unsigned DC  = 64'((2 * k) * (2 * k - 1));
    localparam logic [RCW-1:0]  RS  = RCW'((64'd1 << F) / DS);
    localparam logic [RCW-1:0]  RC  = RCW'((64'd1 << F) / DC);
    localparam bit              ODD = (k % 2) == 1;

    logic [PW-1:0]        p_s, p_c;
    logic [TW-1:0]        t_s, t_c;
    logic [XW-1:0]        d_x2  [0:3];
    logic signed [SW-1:0] d_ss  [0:3];
    logic signed [SW-1:0] d_sc  [0:3];
    logic                 d_neg [0:3];
    logic [ACT_W-1:0]     d_act [0:3];
    logic                 d_v   [0:3];

    tsct_mul #(.AW(TW), .BW(XW), .SH(F), .OW(PW)) u_sq_s (
      .clk (clk), .a (ch_ts[k-1]), .b (ch_x2[k-1]), .p (p_s)
    );
    tsct_mul #(.AW(TW), .BW(XW), .SH(F), .OW(PW)) u_sq_c (
      .clk (clk), .a (ch_tc[k-1]), .b (ch_x2[k-1]), .p (p_c)
    );
    tsct_mul #(.AW(PW), .BW(RCW), .SH(F), .OW(TW)) u_rc_s (
      .clk (clk), .a (p_s), .b (RS), .p (t_s)
    );
    tsct_mul #(.AW(PW), .BW(RCW), .SH(F), .OW(TW)) u_rc_c (
      .clk (clk), .a (p_c), .b (RC), .p (t_c)
    );

    always_ff @(posedge clk) begin
      d_x2[0]  <= ch_x2[k-1];
      d_ss[0]  <= ch_ss[k-1];
      d_sc[0]  <= ch_sc[k-1];
      d_neg[0] <= ch_neg[k-1];
      d_act[0] <= ch_act[k-1];
      for (int i = 1; i < 4; i++) begin
        d_x2[i]  <= d_x2[i-1];
        d_ss[i]  <= d_ss[i-1];
        d_sc[i]  <= d_sc[i-1];
        d_neg[i] <= d_neg[i-1];
        d_act[i] <= d_act[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int i = 0; i < 4; i++) begin
          d_v[i] <= 1'b0;
        end
        ch_v[k] <= 1'b0;
      end else begin
        d_v[0] <= ch_v[k-1];
        for (int i = 1; i < 4; i++) begin
          d_v[i] <= d_v[i-1];
        end
        ch_v[k] <= d_v[3];
      end
    end

    // alternating signs: odd steps subtract
    always_ff @(posedge clk) begin
      ch_x2[k]  <= d_x2[3];
      ch_ts[k]  <= t_s;
      ch_tc[k]  <= t_c;
      ch_ss[k]  <= ODD ? d_ss[3] - SW'($signed({1'b0, t_s}))
                       : d_ss[3] + SW'($signed({1'b0, t_s}));
      ch_sc[k]  <= ODD ? d_sc[3] - SW'($signed({1'b0, t_c}))
                       : d_sc[3] + SW'($signed({1'b0, t_c}));
      ch_neg[k] <= d_neg[3];
      ch_act[k] <= d_act[3];
    end
  end

  // ---------------- sign fix-up ----------------
  logic signed [SW-1:0] e_s_r, e_c_r;
  logic [ACT_W-1:0]     e_act_r;
  logic                 e_v_r;

  always_ff @(posedge clk) begin
    e_s_r   <= ch_neg[TERMS-1] ? -ch_ss[TERMS-1] : ch_ss[TERMS-1];
    e_c_r   <= ch_sc[TERMS-1];
    e_act_r <= ch_act[TERMS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else begin
      e_v_r <= ch_v[TERMS-1];
    end
  end

  // ---------------- saturation and divider setup ----------------
  logic signed [EW-1:0] sc_w;
  logic signed [OUT_W-1:0] sc_val;
  logic                 sc_ovf;
  logic [SW-1:0]        n_mag, d_mag;
  logic [VW-1:0]        num_w, den_w, lim_w;
  logic                 q_neg, c_zero, t_ovf;

  assign sc_w = (e_act_r == ACT_SIN) ? EW'(e_s_r) : EW'(e_c_r);

  always_comb begin
    sc_ovf = 1'b0;
    sc_val = OUT_W'(sc_w);
    if (sc_w > MAX_E) begin
      sc_ovf = 1'b1;
      sc_val = OUT_MAX;
    end else if (sc_w < MIN_E) begin
      sc_ovf = 1'b1;
      sc_val = OUT_MIN;
    end
  end

  assign n_mag  = e_s_r[SW-1] ? SW'(-e_s_r) : SW'(e_s_r);
  assign d_mag  = e_c_r[SW-1] ? SW'(-e_c_r) : SW'(e_c_r);
  assign q_neg  = e_s_r[SW-1] != e_c_r[SW-1];
  assign c_zero = e_c_r == '0;
  assign num_w  = VW'(n_mag) << F;
  assign den_w  = VW'(d_mag);
  // quotient beyond the limit when n*2^F >= (limit+1)*d
  assign lim_w  = (den_w << (OUT_W - 1)) + (q_neg ? den_w : '0);
  assign t_ovf  = num_w >= lim_w;

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic [VW-1:0]        dv_rem   [0:QB];
  logic [VW-1:0]        dv_den   [0:QB];
  logic [QB-1:0]        dv_q     [0:QB];
  logic [ACT_W-1:0]     dv_act   [0:QB];
  logic signed [OUT_W-1:0] dv_sc  [0:QB];
  logic                 dv_scovf [0:QB];
  logic                 dv_qneg  [0:QB];
  logic                 dv_czero [0:QB];
  logic                 dv_sneg  [0:QB];
  logic                 dv_tovf  [0:QB];
  logic                 dv_v     [0:QB];

  always_ff @(posedge clk) begin
    dv_rem[0]   <= num_w;
    dv_den[0]   <= den_w;
    dv_q[0]     <= '0;
    dv_act[0]   <= e_act_r;
    dv_sc[0]    <= sc_val;
    dv_scovf[0] <= sc_ovf;
    dv_qneg[0]  <= q_neg;
    dv_czero[0] <= c_zero;
    dv_sneg[0]  <= e_s_r[SW-1];
    dv_tovf[0]  <= t_ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= e_v_r;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SHB = QB - 1 - j;

    logic [VW-1:0] sub_d;
    logic          take;

    assign sub_d = dv_den[j] << SHB;
    assign take  = dv_rem[j] >= sub_d;

    always_ff @(posedge clk) begin
      dv_rem[j+1]   <= take ? dv_rem[j] - sub_d : dv_rem[j];
      dv_den[j+1]   <= dv_den[j];
      dv_q[j+1]     <= {dv_q[j][QB-2:0], take};
      dv_act[j+1]   <= dv_act[j];
      dv_sc[j+1]    <= dv_sc[j];
      dv_scovf[j+1] <= dv_scovf[j];
      dv_qneg[j+1]  <= dv_qneg[j];
      dv_czero[j+1] <= dv_czero[j];
      dv_sneg[j+1]  <= dv_sneg[j];
      dv_tovf[j+1]  <= dv_tovf[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
    end
  end

  // ---------------- result select ----------------
  logic signed [OUT_W-1:0] val_nxt;
  logic                    ovf_nxt;
  logic [QB-1:0]           q_fin;

  assign q_fin = dv_q[QB];

  always_comb begin
    val_nxt = '0;
    ovf_nxt = 1'b0;
    case (dv_act[QB])
      ACT_SIN, ACT_COS: begin
        val_nxt = dv_sc[QB];
        ovf_nxt = dv_scovf[QB];
      end
      ACT_TAN: begin
        if (dv_czero[QB]) begin
          // cosine zero: saturate toward the sine's sign
          val_nxt = dv_sneg[QB] ? OUT_MIN : OUT_MAX;
          ovf_nxt = 1'b1;
        end else if (dv_tovf[QB]) begin
          val_nxt = dv_qneg[QB] ? OUT_MIN : OUT_MAX;
          ovf_nxt = 1'b1;
        end else begin
          val_nxt = dv_qneg[QB] ? $signed(~q_fin + QB'(1)) : $signed(q_fin);
        end
      end
      default: begin
        val_nxt = '0;
        ovf_nxt = 1'b0;
      end
    endcase
  end

  logic signed [OUT_W-1:0] out_value_r;
  logic                    out_overflow_r;
  logic                    out_valid_r;

  always_ff @(posedge clk) begin
    out_value_r    <= val_nxt;
    out_overflow_r <= ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v[QB];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_overflow = out_overflow_r;

endmodule

// ===== rtl/core/tsct_mul.sv =====
// two-stage unsigned multiplier with truncating right shift, split into four partial products
module tsct_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SH = 28,
  parameter int OW = 36
) (
  input  logic          clk,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [OW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int FW = AW + BW;

  logic [AL+BL-1:0] pp_ll_r;
  logic [AL+BH-1:0] pp_lh_r;
  logic [AH+BL-1:0] pp_hl_r;
  logic [AH+BH-1:0] pp_hh_r;
  logic [FW-1:0]    full;
  logic [OW-1:0]    p_r;

  always_ff @(posedge clk) begin
    pp_ll_r <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
    pp_lh_r <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
    pp_hl_r <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
    pp_hh_r <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
  end

  // low a times high b sits at the b split, high a times low b at the a split
  assign full = FW'(pp_ll_r) + (FW'(pp_lh_r) << BL) + (FW'(pp_hl_r) << AL)
              + (FW'(pp_hh_r) << (AL + BL));

  always_ff @(posedge clk) begin
    p_r <= OW'(full >> SH);
  end

  assign p = p_r;

endmodule
